/* src/cau_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg: shared types and helpers of the complex arithmetic unit
// Word format, command and response records, and saturation helpers.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int EXP_BITS  = 8;

	// Accumulator width: holds a sum of two full products with headroom.
	localparam int ACC_BITS = 2 * WORD_BITS + 2;
	// Dividend width of the iterative unit: magnitude shifted up by the fraction.
	localparam int DVD_BITS = 2 * WORD_BITS + FRAC_BITS;
	localparam int CNT_BITS = $clog2(DVD_BITS + 1);

	localparam logic [2:0] ACT_ADD = 3'd0;
	localparam logic [2:0] ACT_SUB = 3'd1;
	localparam logic [2:0] ACT_MUL = 3'd2;
	localparam logic [2:0] ACT_DIV = 3'd3;
	localparam logic [2:0] ACT_POW = 3'd4;
	localparam logic [2:0] ACT_MOD = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	typedef struct packed {
		logic [2:0]                  action;
		logic signed [WORD_BITS-1:0] a_re;
		logic signed [WORD_BITS-1:0] a_im;
		logic signed [WORD_BITS-1:0] b_re;
		logic signed [WORD_BITS-1:0] b_im;
		logic [EXP_BITS-1:0]         exponent;
	} cmd_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] res_re;
		logic signed [WORD_BITS-1:0] res_im;
		logic [1:0]                  status;
	} rsp_t;

	typedef struct packed {
		logic                 ovf;
		logic [WORD_BITS-1:0] val;
	} sat_t;

	typedef struct packed {
		logic start;
		logic sqrt;
	} it_req_t;

	localparam logic [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	// Saturate a signed accumulator value to one word.
	function automatic sat_t sat_s(input logic signed [ACC_BITS-1:0] v);
		sat_t r;
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &v[ACC_BITS-1:WORD_BITS-1];
		hi_zeros = ~|v[ACC_BITS-1:WORD_BITS-1];
		r.ovf = !(hi_ones || hi_zeros);
		if (r.ovf) r.val = v[ACC_BITS-1] ? W_MIN : W_MAX;
		else r.val = v[WORD_BITS-1:0];
		return r;
	endfunction

	// Saturate a sign and magnitude value; big marks magnitude bits lost above.
	function automatic sat_t sat_m(input logic neg, input logic big,
			input logic [WORD_BITS:0] mag);
		sat_t r;
		if (!neg) begin
			r.ovf = big | mag[WORD_BITS] | mag[WORD_BITS-1];
			r.val = r.ovf ? W_MAX : mag[WORD_BITS-1:0];
		end else begin
			r.ovf = big | mag[WORD_BITS] | (mag[WORD_BITS-1] & (|mag[WORD_BITS-2:0]));
			r.val = r.ovf ? W_MIN : (~mag[WORD_BITS-1:0] + 1'b1);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* src/complex_arithmetic_unit_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core: complex arithmetic on signed Q16.16 words
// Add, subtract, multiply, divide, integer power and modulus, built around one
// shared 32x32 multiplier and one bit-serial divide / square-root unit.
// ----------------------------------------------------------------------------
// Unknown actions and power with exponent 0 or 1 finish straight from idle,
// so busy stays low for them. Add and subtract pass S_POST; multiply runs the
// shared multiplier, divide adds two serial divisions unless the divisor is
// zero, modulus one square root, and power repeats the complex product. busy
// is high whenever the sequencer is out of idle.
// Reset clears the sequencer and the done strobe; the receiver cannot stall.
module complex_arithmetic_unit_core (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  cau_pkg::cmd_t    cmd,
	output logic             done,
	output cau_pkg::rsp_t    rsp
);
	import cau_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MULT,
		S_DRAIN,
		S_POST,
		S_DIVRE,
		S_DIVIM,
		S_SQRT
	} state_t;

	state_t state_q;

	// Latched transaction operands.
	logic [2:0]                  op_q;
	logic signed [WORD_BITS-1:0] ar_q, ai_q, br_q, bi_q;
	// Running power value.
	logic signed [WORD_BITS-1:0] hr_q, hi_q;
	logic [EXP_BITS-1:0]         cnt_q;
	logic [2:0]                  k_q;
	logic                        ovf_q;
	logic [WORD_BITS-1:0]        re_keep_q;

	// Multiplier output stage and its tag.
	logic signed [2*WORD_BITS-1:0] prod_s1;
	logic [2:0]                    pk_s1;
	logic                          pv_s1;

	logic signed [ACC_BITS-1:0] acc_re_q, acc_im_q, acc_d_q;

	logic  done_q;
	rsp_t  rsp_q;

	logic signed [WORD_BITS-1:0] mx, my;
	logic [2:0]                  k_last;

	it_req_t                 it_req;
	logic [2*WORD_BITS-1:0]  it_num;
	logic                    it_done;
	logic [WORD_BITS:0]      it_quo;
	logic                    it_big;

	logic signed [ACC_BITS-1:0] prod_x;
	logic signed [ACC_BITS-1:0] mag_re, mag_im;
	sat_t s_re, s_im, s_add_re, s_add_im, s_one, s_q;
	logic signed [ACC_BITS-1:0] sum_re, sum_im;

	// Operand selection for the shared multiplier, by action and step.
	// Multiply and power form xr*yr, xi*yi, xr*yi, xi*yr. Divide first forms
	// the divisor norm, then the two numerator pairs. Modulus forms the norm of a.
	always_comb begin
		mx = ar_q;
		my = br_q;
		k_last = 3'd3;
		unique case (op_q)
			ACT_DIV: begin
				k_last = 3'd5;
				unique case (k_q)
					3'd0: begin mx = br_q; my = br_q; end
					3'd1: begin mx = bi_q; my = bi_q; end
					3'd2: begin mx = ar_q; my = br_q; end
					3'd3: begin mx = ai_q; my = bi_q; end
					3'd4: begin mx = ai_q; my = br_q; end
					default: begin mx = ar_q; my = bi_q; end
				endcase
			end
			ACT_MOD: begin
				k_last = 3'd1;
				if (k_q == 3'd0) begin
					mx = ar_q; my = ar_q;
				end else begin
					mx = ai_q; my = ai_q;
				end
			end
			ACT_POW: begin
				unique case (k_q)
					3'd0: begin mx = hr_q; my = ar_q; end
					3'd1: begin mx = hi_q; my = ai_q; end
					3'd2: begin mx = hr_q; my = ai_q; end
					default: begin mx = hi_q; my = ar_q; end
				endcase
			end
			default: begin
				unique case (k_q)
					3'd0: begin mx = ar_q; my = br_q; end
					3'd1: begin mx = ai_q; my = bi_q; end
					3'd2: begin mx = ar_q; my = bi_q; end
					default: begin mx = ai_q; my = br_q; end
				endcase
			end
		endcase
	end

	assign prod_x = ACC_BITS'(prod_s1);

	// Result shaping of the accumulators.
	always_comb begin
		s_re   = sat_s(acc_re_q >>> FRAC_BITS);
		s_im   = sat_s(acc_im_q >>> FRAC_BITS);
		sum_re = (op_q == ACT_SUB) ? (ACC_BITS'(ar_q) - ACC_BITS'(br_q))
		                           : (ACC_BITS'(ar_q) + ACC_BITS'(br_q));
		sum_im = (op_q == ACT_SUB) ? (ACC_BITS'(ai_q) - ACC_BITS'(bi_q))
		                           : (ACC_BITS'(ai_q) + ACC_BITS'(bi_q));
		s_add_re = sat_s(sum_re);
		s_add_im = sat_s(sum_im);
		s_one  = sat_s(ACC_BITS'(1) <<< FRAC_BITS);
		mag_re = acc_re_q[ACC_BITS-1] ? -acc_re_q : acc_re_q;
		mag_im = acc_im_q[ACC_BITS-1] ? -acc_im_q : acc_im_q;
		if (state_q == S_SQRT) s_q = sat_m(1'b0, 1'b0, it_quo);
		else if (state_q == S_DIVRE) s_q = sat_m(acc_re_q[ACC_BITS-1], it_big, it_quo);
		else s_q = sat_m(acc_im_q[ACC_BITS-1], it_big, it_quo);
	end

	// Divide / square-root requests leave from S_POST and S_DIVRE.
	always_comb begin
		it_req.start = 1'b0;
		it_req.sqrt  = (op_q == ACT_MOD);
		it_num       = mag_re[2*WORD_BITS-1:0];
		if (state_q == S_POST) begin
			if (op_q == ACT_MOD) begin
				it_req.start = 1'b1;
				it_num       = acc_d_q[2*WORD_BITS-1:0];
			end else if (op_q == ACT_DIV && acc_d_q != '0) begin
				it_req.start = 1'b1;
			end
		end else if (state_q == S_DIVRE && it_done) begin
			it_req.start = 1'b1;
			it_num       = mag_im[2*WORD_BITS-1:0];
		end
	end

	cau_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (it_req),
		.num    (it_num),
		.den    (acc_d_q[2*WORD_BITS-1:0]),
		.done   (it_done),
		.quo    (it_quo),
		.big    (it_big)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			pv_s1   <= 1'b0;
			op_q    <= ACT_ADD;
			k_q     <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;

			// The multiplier stage: one product per cycle while in S_MULT.
			prod_s1 <= mx * my;
			pk_s1   <= k_q;
			pv_s1   <= (state_q == S_MULT);

			// Fold the previous product into its accumulator.
			if (pv_s1) begin
				if (op_q == ACT_DIV) begin
					unique case (pk_s1)
						3'd0: acc_d_q <= prod_x;
						3'd1: acc_d_q <= acc_d_q + prod_x;
						3'd2: acc_re_q <= prod_x;
						3'd3: acc_re_q <= acc_re_q + prod_x;
						3'd4: acc_im_q <= prod_x;
						default: acc_im_q <= acc_im_q - prod_x;
					endcase
				end else if (op_q == ACT_MOD) begin
					if (pk_s1 == 3'd0) acc_d_q <= prod_x;
					else acc_d_q <= acc_d_q + prod_x;
				end else begin
					unique case (pk_s1)
						3'd0: acc_re_q <= prod_x;
						3'd1: acc_re_q <= acc_re_q - prod_x;
						3'd2: acc_im_q <= prod_x;
						default: acc_im_q <= acc_im_q + prod_x;
					endcase
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q  <= cmd.action;
						ar_q  <= cmd.a_re;
						ai_q  <= cmd.a_im;
						br_q  <= cmd.b_re;
						bi_q  <= cmd.b_im;
						hr_q  <= cmd.a_re;
						hi_q  <= cmd.a_im;
						cnt_q <= cmd.exponent - 1'b1;
						k_q   <= '0;
						ovf_q <= 1'b0;
						priority case (cmd.action)
							ACT_ADD, ACT_SUB: state_q <= S_POST;
							ACT_MUL, ACT_DIV, ACT_MOD: state_q <= S_MULT;
							ACT_POW: begin
								if (cmd.exponent == '0) begin
									done_q        <= 1'b1;
									rsp_q.res_re  <= s_one.val;
									rsp_q.res_im  <= '0;
									rsp_q.status  <= s_one.ovf ? ST_OVF : ST_OK;
								end else if (cmd.exponent == EXP_BITS'(1)) begin
									done_q        <= 1'b1;
									rsp_q.res_re  <= cmd.a_re;
									rsp_q.res_im  <= cmd.a_im;
									rsp_q.status  <= ST_OK;
								end else begin
									state_q <= S_MULT;
								end
							end
							default: begin
								done_q       <= 1'b1;
								rsp_q.res_re <= '0;
								rsp_q.res_im <= '0;
								rsp_q.status <= ST_OK;
							end
						endcase
					end
				end

				S_MULT: begin
					k_q <= k_q + 1'b1;
					if (k_q == k_last) state_q <= S_DRAIN;
				end

				S_DRAIN: begin
					state_q <= S_POST;
				end

				S_POST: begin
					k_q <= '0;
					unique case (op_q)
						ACT_ADD, ACT_SUB: begin
							done_q       <= 1'b1;
							rsp_q.res_re <= s_add_re.val;
							rsp_q.res_im <= s_add_im.val;
							rsp_q.status <= (s_add_re.ovf | s_add_im.ovf) ? ST_OVF : ST_OK;
							state_q      <= S_IDLE;
						end
						ACT_MUL: begin
							done_q       <= 1'b1;
							rsp_q.res_re <= s_re.val;
							rsp_q.res_im <= s_im.val;
							rsp_q.status <= (s_re.ovf | s_im.ovf) ? ST_OVF : ST_OK;
							state_q      <= S_IDLE;
						end
						ACT_POW: begin
							// Saturated values carry on; overflow is sticky.
							hr_q  <= s_re.val;
							hi_q  <= s_im.val;
							ovf_q <= ovf_q | s_re.ovf | s_im.ovf;
							cnt_q <= cnt_q - 1'b1;
							if (cnt_q == EXP_BITS'(1)) begin
								done_q       <= 1'b1;
								rsp_q.res_re <= s_re.val;
								rsp_q.res_im <= s_im.val;
								rsp_q.status <= (ovf_q | s_re.ovf | s_im.ovf) ? ST_OVF : ST_OK;
								state_q      <= S_IDLE;
							end else begin
								state_q <= S_MULT;
							end
						end
						ACT_DIV: begin
							if (acc_d_q == '0) begin
								done_q       <= 1'b1;
								rsp_q.res_re <= '0;
								rsp_q.res_im <= '0;
								rsp_q.status <= ST_DIV0;
								state_q      <= S_IDLE;
							end else begin
								state_q <= S_DIVRE;
							end
						end
						default: state_q <= S_SQRT;
					endcase
				end

				S_DIVRE: begin
					if (it_done) begin
						re_keep_q <= s_q.val;
						ovf_q     <= s_q.ovf;
						state_q   <= S_DIVIM;
					end
				end

				S_DIVIM: begin
					if (it_done) begin
						done_q       <= 1'b1;
						rsp_q.res_re <= re_keep_q;
						rsp_q.res_im <= s_q.val;
						rsp_q.status <= (ovf_q | s_q.ovf) ? ST_OVF : ST_OK;
						state_q      <= S_IDLE;
					end
				end

				default: begin
					if (it_done) begin
						done_q       <= 1'b1;
						rsp_q.res_re <= s_q.val;
						rsp_q.res_im <= '0;
						rsp_q.status <= s_q.ovf ? ST_OVF : ST_OK;
						state_q      <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
`default_nettype wire

/* src/cau_iter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cau_iter: bit-serial divider and square root
// Restoring division one quotient bit a cycle, or digit-by-digit square root
// one root bit a cycle, both through one shared compare and subtract.
// ----------------------------------------------------------------------------
module cau_iter (
	input  wire                               clk,
	input  wire                               arst_n,
	input  cau_pkg::it_req_t                  req,
	input  wire [2*cau_pkg::WORD_BITS-1:0]    num,
	input  wire [2*cau_pkg::WORD_BITS-1:0]    den,
	output logic                              done,
	output logic [cau_pkg::WORD_BITS:0]       quo,
	output logic                              big
);
	import cau_pkg::*;

	localparam int RW = ACC_BITS;

	logic                    run_q;
	logic                    sqrt_q;
	logic [CNT_BITS-1:0]     cnt_q;
	logic [DVD_BITS-1:0]     sh_q;
	logic [RW-1:0]           rem_q;
	logic [WORD_BITS:0]      q_q;
	logic                    big_q;
	logic [2*WORD_BITS-1:0]  den_q;
	logic                    done_q;

	logic [RW-1:0] rs;
	logic [RW-1:0] cmpv;
	logic          ge;

	always_comb begin
		if (sqrt_q) begin
			rs   = {rem_q[RW-3:0], sh_q[DVD_BITS-1:DVD_BITS-2]};
			cmpv = {{(RW-WORD_BITS-3){1'b0}}, q_q, 2'b01};
		end else begin
			rs   = {rem_q[RW-2:0], sh_q[DVD_BITS-1]};
			cmpv = {{(RW-2*WORD_BITS){1'b0}}, den_q};
		end
		ge = rs >= cmpv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			sqrt_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q  <= 1'b1;
				sqrt_q <= req.sqrt;
				cnt_q  <= req.sqrt ? CNT_BITS'(WORD_BITS) : CNT_BITS'(DVD_BITS);
				sh_q   <= {num, {FRAC_BITS{1'b0}}};
				den_q  <= den;
				rem_q  <= '0;
				q_q    <= '0;
				big_q  <= 1'b0;
			end else if (run_q) begin
				rem_q <= ge ? (rs - cmpv) : rs;
				q_q   <= {q_q[WORD_BITS-1:0], ge};
				big_q <= big_q | q_q[WORD_BITS];
				sh_q  <= sqrt_q ? (sh_q << 2) : (sh_q << 1);
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = q_q;
	assign big  = big_q;

endmodule
`default_nettype wire

/* dv/complex_arithmetic_unit_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core_tb: self-checking bench of the complex unit
// Sends directed and random commands through the start / busy handshake and
// compares every response with a bit-accurate model of the Q16.16 arithmetic.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core_tb;
	import cau_pkg::*;

	// Wide signed type that holds every intermediate sum, product and
	// shifted dividend without loss.
	typedef logic signed [129:0] wd_t;

	localparam wd_t WORD_HI = (wd_t'(1) <<< (WORD_BITS - 1)) - 1;
	localparam wd_t WORD_LO = -(wd_t'(1) <<< (WORD_BITS - 1));

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	cmd_t  cmd;
	logic  done;
	rsp_t  rsp;

	rsp_t  expected_rsp_q[$];
	int    mismatch_count;
	bit    idling_on;

	complex_arithmetic_unit_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Model of the arithmetic
	// ------------------------------------------------------------------------

	// Clamp a wide value to one signed word and flag the overflow.
	function automatic logic [WORD_BITS-1:0] clamp_word(input wd_t v, inout logic ovf);
		if (v > WORD_HI) begin
			ovf = 1'b1;
			return W_MAX;
		end
		if (v < WORD_LO) begin
			ovf = 1'b1;
			return W_MIN;
		end
		return v[WORD_BITS-1:0];
	endfunction

	// One complex product in Q16.16; the shift is arithmetic, so it floors.
	function automatic void complex_product(input logic signed [WORD_BITS-1:0] ar, ai, br, bi,
			output logic [WORD_BITS-1:0] rr, ri, inout logic ovf);
		wd_t re_sum;
		wd_t im_sum;
		re_sum = wd_t'(ar) * wd_t'(br) - wd_t'(ai) * wd_t'(bi);
		im_sum = wd_t'(ar) * wd_t'(bi) + wd_t'(ai) * wd_t'(br);
		rr = clamp_word(re_sum >>> FRAC_BITS, ovf);
		ri = clamp_word(im_sum >>> FRAC_BITS, ovf);
	endfunction

	// Floor square root of a value below 2**64, by the digit-by-digit method.
	function automatic logic [65:0] floor_sqrt(input logic [65:0] v);
		logic [65:0] root;
		logic [65:0] bitv;
		root = '0;
		bitv = 66'd1 << 64;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic rsp_t predict_response(input cmd_t c);
		rsp_t r;
		logic ovf;
		logic div0;
		wd_t den;
		wd_t num;
		logic [WORD_BITS-1:0] hr;
		logic [WORD_BITS-1:0] hi;
		ovf  = 1'b0;
		div0 = 1'b0;
		r    = '0;
		case (c.action)
			ACT_ADD: begin
				r.res_re = clamp_word(wd_t'(c.a_re) + wd_t'(c.b_re), ovf);
				r.res_im = clamp_word(wd_t'(c.a_im) + wd_t'(c.b_im), ovf);
			end
			ACT_SUB: begin
				r.res_re = clamp_word(wd_t'(c.a_re) - wd_t'(c.b_re), ovf);
				r.res_im = clamp_word(wd_t'(c.a_im) - wd_t'(c.b_im), ovf);
			end
			ACT_MUL: begin
				complex_product(c.a_re, c.a_im, c.b_re, c.b_im, hr, hi, ovf);
				r.res_re = hr;
				r.res_im = hi;
			end
			ACT_DIV: begin
				den = wd_t'(c.b_re) * wd_t'(c.b_re) + wd_t'(c.b_im) * wd_t'(c.b_im);
				if (den == 0) begin
					div0 = 1'b1;
				end else begin
					// Signed division truncates toward zero, as the unit does.
					num = wd_t'(c.a_re) * wd_t'(c.b_re) + wd_t'(c.a_im) * wd_t'(c.b_im);
					r.res_re = clamp_word((num <<< FRAC_BITS) / den, ovf);
					num = wd_t'(c.a_im) * wd_t'(c.b_re) - wd_t'(c.a_re) * wd_t'(c.b_im);
					r.res_im = clamp_word((num <<< FRAC_BITS) / den, ovf);
				end
			end
			ACT_POW: begin
				if (c.exponent == 0) begin
					r.res_re = clamp_word(wd_t'(1) <<< FRAC_BITS, ovf);
				end else begin
					hr = c.a_re;
					hi = c.a_im;
					for (int i = 1; i < c.exponent; i++)
						complex_product(hr, hi, c.a_re, c.a_im, hr, hi, ovf);
					r.res_re = hr;
					r.res_im = hi;
				end
			end
			ACT_MOD: begin
				num = wd_t'(c.a_re) * wd_t'(c.a_re) + wd_t'(c.a_im) * wd_t'(c.a_im);
				r.res_re = clamp_word(wd_t'({64'd0, floor_sqrt(num[65:0])}), ovf);
			end
			default: ;
		endcase
		if (div0) r.status = ST_DIV0;
		else if (ovf) r.status = ST_OVF;
		else r.status = ST_OK;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Response checking: every done strobe is matched against the oldest
	// expectation, field by field.
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [31:0] got, want);
		$display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (expected_rsp_q.size() == 0) begin
				report_mismatch("unexpected response", rsp.res_re, 32'd0);
			end else begin
				want = expected_rsp_q.pop_front();
				if (rsp.res_re !== want.res_re)
					report_mismatch("res_re", rsp.res_re, want.res_re);
				if (rsp.res_im !== want.res_im)
					report_mismatch("res_im", rsp.res_im, want.res_im);
				if (rsp.status !== want.status)
					report_mismatch("status", 32'(rsp.status), 32'(want.status));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	// Issue one transaction. Called at a falling edge; returns at the falling
	// edge after the accepting rising edge, with start still high so that a
	// following transaction can go out back to back.
	task automatic send_command(input cmd_t c);
		int gap;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			start = 1'b0;
			gap = $urandom_range(1, 17);
			repeat (gap) @(negedge clk);
		end
		cmd   = c;
		start = 1'b1;
		do @(posedge clk); while (busy);
		expected_rsp_q.push_back(predict_response(c));
		@(negedge clk);
	endtask

	// Operand with a bias toward edges, values that stay in range, and noise.
	function automatic logic [WORD_BITS-1:0] pick_word();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return W_MAX - $urandom_range(0, 2);
			2: return W_MIN + $urandom_range(0, 2);
			3: return $urandom_range(0, 2) - 1;
			default: return WORD_BITS'(signed'($urandom_range(0, 32'h0003_ffff)) - 32'sh0001_ffff);
		endcase
	endfunction

	function automatic cmd_t make_cmd(input logic [2:0] act, input logic [WORD_BITS-1:0] ar, ai,
			br, bi, input logic [EXP_BITS-1:0] ex);
		cmd_t c;
		c.action   = act;
		c.a_re     = ar;
		c.a_im     = ai;
		c.b_re     = br;
		c.b_im     = bi;
		c.exponent = ex;
		return c;
	endfunction

	localparam logic [WORD_BITS-1:0] ONE_Q = 32'h0001_0000;

	task automatic test_directed();
		send_command(make_cmd(ACT_ADD, W_MAX, W_MIN, 32'd1, 32'hffff_ffff, 8'd0));
		send_command(make_cmd(ACT_ADD, W_MIN, W_MAX, W_MIN, W_MAX, 8'hff));
		send_command(make_cmd(ACT_SUB, W_MIN, W_MAX, 32'd1, 32'hffff_ffff, 8'd0));
		send_command(make_cmd(ACT_SUB, 32'd0, 32'd0, W_MIN, W_MAX, 8'd0));
		send_command(make_cmd(ACT_MUL, W_MAX, W_MIN, W_MAX, W_MIN, 8'd0));
		send_command(make_cmd(ACT_MUL, 32'hffff_ffff, 32'd1, 32'd1, 32'd1, 8'd0));
		send_command(make_cmd(ACT_MUL, ONE_Q, ONE_Q, ONE_Q, 32'hffff_0000, 8'd0));
		// A zero divisor gives zero and the divide-by-zero status.
		send_command(make_cmd(ACT_DIV, ONE_Q, W_MIN, 32'd0, 32'd0, 8'd0));
		send_command(make_cmd(ACT_DIV, W_MAX, W_MIN, 32'd1, 32'd0, 8'd0));
		send_command(make_cmd(ACT_DIV, 32'hffff_fffd, 32'd7, 32'h0002_0000, 32'd0, 8'd0));
		send_command(make_cmd(ACT_DIV, W_MIN, W_MIN, W_MIN, W_MIN, 8'd0));
		// Exponent zero yields one, whatever the operand.
		send_command(make_cmd(ACT_POW, W_MIN, W_MAX, W_MAX, W_MAX, 8'd0));
		send_command(make_cmd(ACT_POW, 32'h0000_b505, 32'h0000_b505, 32'd0, 32'd0, 8'd1));
		send_command(make_cmd(ACT_POW, 32'd0, ONE_Q, 32'd0, 32'd0, 8'hff));
		send_command(make_cmd(ACT_POW, W_MAX, 32'd0, 32'd0, 32'd0, 8'd2));
		send_command(make_cmd(ACT_POW, 32'h0002_0000, 32'd0, 32'd0, 32'd0, 8'd40));
		send_command(make_cmd(ACT_MOD, W_MIN, W_MIN, W_MAX, W_MAX, 8'hff));
		send_command(make_cmd(ACT_MOD, 32'h0003_0000, 32'hfffc_0000, 32'd0, 32'd0, 8'd0));
		send_command(make_cmd(ACT_MOD, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0));
		// Actions above modulus return zero with status ok.
		send_command(make_cmd(3'd6, W_MAX, W_MAX, W_MAX, W_MAX, 8'hff));
		send_command(make_cmd(3'd7, W_MIN, W_MIN, W_MIN, W_MIN, 8'hff));
	endtask

	// Exponents are kept short most of the time; a few go to the top of the
	// range so that every exponent bit toggles.
	function automatic logic [EXP_BITS-1:0] pick_exponent();
		if ($urandom_range(0, 19) == 0) return EXP_BITS'($urandom_range(128, 255));
		return EXP_BITS'($urandom_range(0, 12));
	endfunction

	task automatic test_random(input int count, input bit power_heavy);
		logic [2:0] act;
		logic [WORD_BITS-1:0] bi;
		for (int n = 0; n < count; n++) begin
			act = power_heavy && $urandom_range(0, 1) ? ACT_POW : 3'($urandom_range(0, 7));
			// Scalar operations come from a zero imaginary divisor part.
			bi = $urandom_range(0, 4) == 0 ? 32'd0 : pick_word();
			send_command(make_cmd(act, pick_word(), pick_word(), pick_word(), bi,
				pick_exponent()));
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		cmd            = '0;
		mismatch_count = 0;
		idling_on      = 1'b1;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random(700, 1'b0);
		test_random(250, 1'b1);
		idling_on = 1'b0;
		test_random(200, 1'b0);
		start = 1'b0;

		// Drain, then give any stray strobe time to show.
		wait (expected_rsp_q.size() == 0);
		repeat (50) @(negedge clk);
		if (mismatch_count == 0 && expected_rsp_q.size() == 0)
			$display("complex_arithmetic_unit_core: match");
		else
			$display("complex_arithmetic_unit_core: mismatch");
		$finish;
	end

	initial begin
		#60ms;
		$display("complex_arithmetic_unit_core: mismatch");
		$finish;
	end

endmodule
